[hw/rtl/assert_macros.svh]
// Assertion helpers used by the command engine RTL of the seen-device cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/sdc_pkg.sv]
// ----------------------------------------------------------------------------
// Seen-device cache package
// Shared constants, command codes and the stored entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

    localparam int DEPTH_DEFAULT = 24;
    localparam logic [31:0] LIFETIME_RESET = 32'd10000;
    localparam int KEY_W = 48;
    localparam int STAMP_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        CMD_TOUCH  = 2'd0,
        CMD_PRUNE  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [1:0]         kind;
        logic signed [7:0]  dbm;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

`default_nettype wire

[hw/rtl/sdc_ifaces.sv]
// ----------------------------------------------------------------------------
// Seen-device cache channel interfaces
// Valid/ready channels for configuration, commands and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [47:0]       device_addr;
    logic [1:0]        addr_kind;
    logic signed [7:0] signal_dbm;
    logic [31:0]       now_ms;

    modport source (output valid, output cmd, output device_addr, output addr_kind,
                    output signal_dbm, output now_ms, input ready);
    modport sink (input valid, input cmd, input device_addr, input addr_kind,
                  input signal_dbm, input now_ms, output ready);
endinterface

interface sdc_out_if;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [1:0]        hit_kind;
    logic signed [7:0] hit_dbm;
    logic              did_evict;
    logic [4:0]        dropped;
    logic [4:0]        occupancy;

    modport source (output valid, output hit, output hit_kind, output hit_dbm,
                    output did_evict, output dropped, output occupancy, input ready);
    modport sink (input valid, input hit, input hit_kind, input hit_dbm,
                  input did_evict, input dropped, input occupancy, output ready);
endinterface

`default_nettype wire

[hw/rtl/sdc_entry_ram.sv]
// ----------------------------------------------------------------------------
// Seen-device cache entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_entry_ram #(
    parameter int CACHE_DEPTH = sdc_pkg::DEPTH_DEFAULT,
    parameter int IDX_W       = $clog2(CACHE_DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [IDX_W-1:0] waddr,
    input  sdc_pkg::entry_t      wdata,
    input  wire logic            re,
    input  wire logic [IDX_W-1:0] raddr,
    output sdc_pkg::entry_t      rdata
);
    import sdc_pkg::*;

    entry_t mem_array [CACHE_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/sdc_engine.sv]
// ----------------------------------------------------------------------------
// Seen-device cache command engine
// Walks the valid entries through the memory read port and applies the command.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sdc_engine #(
    parameter int CACHE_DEPTH = sdc_pkg::DEPTH_DEFAULT,
    parameter int IDX_W       = $clog2(CACHE_DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    sdc_in_if.sink                in_ch,
    sdc_out_if.source             out_ch,
    input  wire logic [31:0]      lifetime,
    output logic                  mem_we,
    output logic [IDX_W-1:0]      mem_waddr,
    output sdc_pkg::entry_t       mem_wdata,
    output logic                  mem_re,
    output logic [IDX_W-1:0]      mem_raddr,
    input  sdc_pkg::entry_t       mem_rdata
);
    import sdc_pkg::*;

    localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CACHE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    cmd_t              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [1:0]        kind_reg;
    logic signed [7:0] dbm_reg;
    logic [31:0]       now_reg;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] keep_reg, keep_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [1:0]        hit_kind_reg;
    logic signed [7:0] hit_dbm_reg;
    logic [31:0]       min_stamp_reg;
    logic [IDX_W-1:0]  min_idx_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg;
    logic [1:0]        out_kind_reg;
    logic signed [7:0] out_dbm_reg;
    logic              out_evict_reg;
    logic [4:0]        out_dropped_reg;
    logic [4:0]        out_occ_reg;

    logic             accept;
    logic             more;
    logic             process;
    logic             key_match;
    logic             keep_entry;
    logic [31:0]      age;
    logic             out_free;
    logic             finish;
    logic             key_cmd;
    logic             res_hit;
    logic             res_evict;
    logic [CNT_W-1:0] res_fill;
    logic [CNT_W-1:0] res_dropped;
    logic [IDX_W-1:0] touch_idx;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    assign more    = (scan_reg < fill_reg);
    assign process = (state_reg == ST_SCAN) && pend_reg;

    assign key_match  = (mem_rdata.key == key_reg);
    assign age        = now_reg - mem_rdata.stamp;
    assign keep_entry = (age <= lifetime);

    assign out_free = !out_valid_reg || out_ch.ready;
    assign finish   = (state_reg == ST_RESULT) && out_free;
    assign key_cmd  = (cmd_reg == CMD_TOUCH) || (cmd_reg == CMD_LOOKUP);
    assign res_hit  = hit_reg && key_cmd;

    // Touch target: the matching entry, else the next free slot, else the stalest entry.
    always_comb
    begin
        res_evict   = 1'b0;
        res_fill    = fill_reg;
        res_dropped = '0;
        touch_idx   = min_idx_reg;
        unique case (cmd_reg)
            CMD_TOUCH:
            begin
                if (hit_reg)
                begin
                    touch_idx = hit_idx_reg;
                end
                else if (fill_reg < DEPTH_CNT)
                begin
                    touch_idx = fill_reg[IDX_W-1:0];
                    res_fill  = fill_reg + CNT_W'(1);
                end
                else
                begin
                    res_evict = 1'b1;
                end
            end
            CMD_PRUNE:
            begin
                res_fill    = keep_reg;
                res_dropped = fill_reg - keep_reg;
            end
            CMD_LOOKUP, CMD_UNUSED:
            begin
                res_fill = fill_reg;
            end
            default:
            begin
                res_fill = fill_reg;
            end
        endcase
    end

    // Memory ports: reads walk the entries; prune compacts survivors downward,
    // a touch writes its one entry when the result is handed over.
    assign mem_re    = (state_reg == ST_SCAN) && more;
    assign mem_raddr = scan_reg[IDX_W-1:0];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = touch_idx;
        mem_wdata = '{key: key_reg, kind: kind_reg, dbm: dbm_reg, stamp: now_reg};
        if (process && (cmd_reg == CMD_PRUNE))
        begin
            mem_we    = keep_entry;
            mem_waddr = keep_reg[IDX_W-1:0];
            mem_wdata = mem_rdata;
        end
        else if (finish && (cmd_reg == CMD_TOUCH))
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        keep_next      = keep_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    scan_next  = '0;
                    keep_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (more)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_RESULT;
                end
                if (process && (cmd_reg == CMD_PRUNE) && keep_entry)
                begin
                    keep_next = keep_reg + CNT_W'(1);
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    fill_next      = res_fill;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            keep_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            keep_reg      <= keep_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and search results.
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        if (accept)
        begin
            cmd_reg  <= cmd_t'(in_ch.cmd);
            key_reg  <= in_ch.device_addr;
            kind_reg <= in_ch.addr_kind;
            dbm_reg  <= in_ch.signal_dbm;
            now_reg  <= in_ch.now_ms;
            hit_reg  <= 1'b0;
        end
        if (process && key_match && !hit_reg)
        begin
            hit_reg      <= 1'b1;
            hit_idx_reg  <= pend_idx_reg;
            hit_kind_reg <= mem_rdata.kind;
            hit_dbm_reg  <= mem_rdata.dbm;
        end
        // Strict compare keeps the lowest index among equal stamps.
        if (process && ((pend_idx_reg == '0) || (mem_rdata.stamp < min_stamp_reg)))
        begin
            min_stamp_reg <= mem_rdata.stamp;
            min_idx_reg   <= pend_idx_reg;
        end
        if (finish)
        begin
            out_hit_reg     <= res_hit;
            out_kind_reg    <= res_hit ? hit_kind_reg : 2'd0;
            out_dbm_reg     <= res_hit ? hit_dbm_reg : 8'sd0;
            out_evict_reg   <= res_evict && !hit_reg;
            out_dropped_reg <= COUNT_W'(res_dropped);
            out_occ_reg     <= COUNT_W'(res_fill);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.hit       = out_hit_reg;
    assign out_ch.hit_kind  = out_kind_reg;
    assign out_ch.hit_dbm   = out_dbm_reg;
    assign out_ch.did_evict = out_evict_reg;
    assign out_ch.dropped   = out_dropped_reg;
    assign out_ch.occupancy = out_occ_reg;

    `SDC_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= DEPTH_CNT)
    `SDC_ASSERT_IMPL(a_compact_down, clk, rst_n, mem_we && (state_reg == ST_SCAN), keep_reg <= CNT_W'(pend_idx_reg))
    `SDC_ASSERT_NEXT(a_accept_scan, clk, rst_n, accept, state_reg == ST_SCAN)

endmodule

`default_nettype wire

[hw/rtl/seen_device_cache_lru_ttl_core.sv]
// Each accepted item walks only the valid entries, one read per cycle on the single
// memory port, and then registers its result; the next item is accepted only once the
// block is back in idle, so the walk sets the rate and items never overlap. A result
// not yet taken holds the next one back behind the output register.
// Reset clears the entry count and loads lifetime_ms with 10000; memory is not cleared.
// ----------------------------------------------------------------------------
// Seen-device cache top level
// Recently seen device table keyed by 48-bit address, with stalest-entry
// replacement on a full table and lifetime-based pruning.
// ----------------------------------------------------------------------------
`default_nettype none

module seen_device_cache_lru_ttl_core #(
    parameter int CACHE_DEPTH = sdc_pkg::DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sdc_cfg_if.sink   cfg_ch,
    sdc_in_if.sink    in_ch,
    sdc_out_if.source out_ch
);
    import sdc_pkg::*;

    localparam int IDX_W = $clog2(CACHE_DEPTH);

    // The lifetime register. Writes are to arrive only while the block is idle;
    // the block itself does not enforce this, and the port is always ready.
    logic [31:0] lifetime_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_rdata;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFETIME_RESET;
        end
        else if (cfg_ch.valid)
        begin
            lifetime_reg <= cfg_ch.data;
        end
    end

    // The engine walks the valid entries in order. A touch or lookup compares
    // every key and tracks the smallest raw stamp for a possible eviction; a
    // prune writes each surviving entry back at the next compacted position,
    // which never passes the read position, so no forwarding is needed.
    sdc_engine #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .lifetime  (lifetime_reg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Key, type, strength and stamp of each entry share one memory word.
    sdc_entry_ram #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
